/* hdl/rfpe_pkg.sv */
`timescale 1ns / 1ps
// Package for the remote-frame pulse encoder: word types, control bundles,
// micro-operation codes, register indexes and frame constants.
// No dependencies.
package rfpe_pkg;

    typedef struct packed {
        logic        opcode;
        logic        heating_kind;
        logic [15:0] house_code;
        logic [7:0]  device_address;
        logic [7:0]  command_byte;
        logic [7:0]  extension_byte;
    } item_t;

    typedef struct packed {
        logic        bit_value;
        logic [11:0] on_time_us;
        logic [10:0] off_time_us;
        logic        frame_end;
        logic        message_end;
    } result_t;

    typedef enum logic [3:0] {
        OP_NOP,
        OP_LATCH,
        OP_ADD_LO,
        OP_ADD_ADDR,
        OP_ADD_CMD,
        OP_ADD_EXT,
        OP_ARM,
        OP_BIT,
        OP_EMIT
    } dp_op_t;

    typedef struct packed {
        dp_op_t op;
    } ctrl_t;

    typedef struct packed {
        logic active;
        logic ext_flag;
    } status_t;

    localparam logic       OPC_LOAD    = 1'b0;
    localparam logic       OPC_ADVANCE = 1'b1;

    localparam logic [2:0] CFG_ONE_WIDTH  = 3'd0;
    localparam logic [2:0] CFG_ZERO_WIDTH = 3'd1;
    localparam logic [2:0] CFG_ON_EXTEND  = 3'd2;
    localparam logic [2:0] CFG_OFF_TRIM   = 3'd3;
    localparam logic [2:0] CFG_REPEAT     = 3'd4;

    localparam logic [7:0] SEED_SWITCH  = 8'h06;
    localparam logic [7:0] SEED_HEATING = 8'h0C;
    localparam int         EXT_BIT      = 5;

    localparam logic [6:0] SYNC_ONE_POS     = 7'd12;
    localparam logic [6:0] FIRST_BYTE_POS   = 7'd13;
    localparam logic [7:0] FRAME_BITS_SHORT = 8'd59;
    localparam logic [7:0] FRAME_BITS_LONG  = 8'd68;
    localparam logic [2:0] BYTES_SHORT      = 3'd5;
    localparam logic [2:0] BYTES_LONG       = 3'd6;
    localparam logic [3:0] PARITY_SLOT      = 4'd8;

endpackage

/* hdl/rfpe_sequencer.sv */
`timescale 1ns / 1ps
// Microcode sequencer: program ROM, step counter and conditional jumps.
// Depends on rfpe_pkg.
module rfpe_sequencer (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              go,
    input  logic              opcode,
    input  rfpe_pkg::status_t status,
    output logic              busy,
    output rfpe_pkg::ctrl_t   ctrl
);
    import rfpe_pkg::*;

    typedef enum logic [2:0] {
        COND_NEVER,
        COND_ALWAYS,
        COND_ACTIVE,
        COND_IDLE,
        COND_NO_EXT
    } cond_t;

    typedef struct packed {
        dp_op_t     op;
        cond_t      cond;
        logic [3:0] target;
        logic       last;
    } ucode_t;

    localparam logic [3:0] ENTRY_LOAD = 4'd0;
    localparam logic [3:0] STEP_ARM   = 4'd6;
    localparam logic [3:0] ENTRY_ADV  = 4'd7;
    localparam logic [3:0] STEP_END   = 4'd10;

    function automatic ucode_t rom_word(input logic [3:0] addr);
        ucode_t w;
        case (addr)
            4'd0:    w = '{OP_NOP,      COND_ACTIVE, STEP_END, 1'b0};
            4'd1:    w = '{OP_LATCH,    COND_NEVER,  STEP_END, 1'b0};
            4'd2:    w = '{OP_ADD_LO,   COND_NEVER,  STEP_END, 1'b0};
            4'd3:    w = '{OP_ADD_ADDR, COND_NEVER,  STEP_END, 1'b0};
            4'd4:    w = '{OP_ADD_CMD,  COND_NO_EXT, STEP_ARM, 1'b0};
            4'd5:    w = '{OP_ADD_EXT,  COND_NEVER,  STEP_END, 1'b0};
            4'd6:    w = '{OP_ARM,      COND_NEVER,  STEP_END, 1'b1};
            4'd7:    w = '{OP_NOP,      COND_IDLE,   STEP_END, 1'b0};
            4'd8:    w = '{OP_BIT,      COND_NEVER,  STEP_END, 1'b0};
            4'd9:    w = '{OP_EMIT,     COND_NEVER,  STEP_END, 1'b1};
            default: w = '{OP_NOP,      COND_NEVER,  STEP_END, 1'b1};
        endcase
        return w;
    endfunction

    logic [3:0] pc_reg, pc_next;
    logic       run_reg, run_next;
    ucode_t     word;
    logic       take_jump;

    always_comb
    begin
        word = rom_word(pc_reg);
        case (word.cond)
            COND_ALWAYS: take_jump = 1'b1;
            COND_ACTIVE: take_jump = status.active;
            COND_IDLE:   take_jump = !status.active;
            COND_NO_EXT: take_jump = !status.ext_flag;
            default:     take_jump = 1'b0;
        endcase

        pc_next  = pc_reg;
        run_next = run_reg;
        if (run_reg)
        begin
            if (word.last)
                run_next = 1'b0;
            else if (take_jump)
                pc_next = word.target;
            else
                pc_next = pc_reg + 4'd1;
        end
        else if (go)
        begin
            run_next = 1'b1;
            pc_next  = (opcode == OPC_ADVANCE) ? ENTRY_ADV : ENTRY_LOAD;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg  <= ENTRY_LOAD;
            run_reg <= 1'b0;
        end
        else
        begin
            pc_reg  <= pc_next;
            run_reg <= run_next;
        end
    end

    assign busy    = run_reg;
    assign ctrl.op = run_reg ? word.op : OP_NOP;

endmodule

/* hdl/rf_remote_frame_pulse_encoder.sv */
`timescale 1ns / 1ps
// Remote-control pulse-width frame encoder, top level: datapath, config
// registers and the microcode sequencer. Depends on rfpe_pkg, rfpe_sequencer.
//
// Usage: present a word on item and raise start; it is taken at the clock
// edge where start is high and busy is low. A load word (opcode 0) stores
// house code, address, command and extension byte and builds the checksum
// from a seed set by the device kind; it gives no result. Each advance word (opcode 1) gives one
// result word: bit value, carrier-on and carrier-off durations and the
// frame_end / message_end marks. A load while a message is in progress and
// an advance with no message loaded are dropped.
// Timing: busy stays high while the microcode program runs; a load runs
// the latch, checksum and arm steps (no extension step without extension
// byte). The result word sits on result for one cycle with result_valid,
// in the first cycle with busy low again; the receiver cannot stall it.
// Config writes (cfg_wr_en, cfg_index, cfg_data) take effect at once;
// indexes beyond the repeat count register are ignored.
// Reset clears the message state and restores register defaults.
module rf_remote_frame_pulse_encoder (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  rfpe_pkg::item_t   item,
    output logic              result_valid,
    output rfpe_pkg::result_t result,
    input  logic              cfg_wr_en,
    input  logic [2:0]        cfg_index,
    input  logic [10:0]       cfg_data
);
    import rfpe_pkg::*;

    logic [10:0] one_width_reg;
    logic [10:0] zero_width_reg;
    logic [9:0]  on_extend_reg;
    logic [9:0]  off_trim_reg;
    logic [2:0]  repeat_reg;

    item_t       item_reg;
    logic [15:0] house_reg;
    logic [7:0]  addr_reg;
    logic [7:0]  cmd_reg;
    logic [7:0]  ext_reg;
    logic [7:0]  csum_reg;
    logic [6:0]  pos_reg;
    logic [2:0]  byte_reg;
    logic [3:0]  slot_reg;
    logic [2:0]  rep_reg;
    logic        active_reg;
    logic        bit_reg;
    logic [10:0] width_reg;
    logic        result_valid_reg;
    result_t     result_reg;

    ctrl_t       ctrl;
    status_t     status;
    logic        accept;

    logic        ext_flag;
    logic [7:0]  cur_byte;
    logic [2:0]  byte_total;
    logic        bit_now;
    logic [11:0] on_time;
    logic [10:0] off_time;
    logic        frame_last;
    logic [2:0]  reps;
    logic        rep_last;

    assign accept          = start && !busy;
    assign ext_flag        = cmd_reg[EXT_BIT];
    assign status.active   = active_reg;
    assign status.ext_flag = ext_flag;

    rfpe_sequencer u_seq (
        .clk    (clk),
        .rst_n  (rst_n),
        .go     (accept),
        .opcode (item.opcode),
        .status (status),
        .busy   (busy),
        .ctrl   (ctrl)
    );

    always_comb
    begin
        case (byte_reg)
            3'd0:    cur_byte = house_reg[15:8];
            3'd1:    cur_byte = house_reg[7:0];
            3'd2:    cur_byte = addr_reg;
            3'd3:    cur_byte = cmd_reg;
            3'd4:    cur_byte = ext_flag ? ext_reg : csum_reg;
            default: cur_byte = csum_reg;
        endcase
        byte_total = ext_flag ? BYTES_LONG : BYTES_SHORT;

        if (pos_reg < SYNC_ONE_POS)
            bit_now = 1'b0;
        else if (pos_reg == SYNC_ONE_POS)
            bit_now = 1'b1;
        else if (byte_reg >= byte_total)
            bit_now = 1'b0;
        else if (slot_reg < PARITY_SLOT)
            bit_now = cur_byte[3'd7 - slot_reg[2:0]];
        else
            bit_now = ^cur_byte;

        on_time  = {1'b0, width_reg} + {2'b00, on_extend_reg};
        off_time = (width_reg > {1'b0, off_trim_reg})
                 ? width_reg - {1'b0, off_trim_reg} : 11'd0;

        frame_last = ({1'b0, pos_reg} + 8'd1)
                  >= (ext_flag ? FRAME_BITS_LONG : FRAME_BITS_SHORT);
        reps       = (repeat_reg == 3'd0) ? 3'd1 : repeat_reg;
        rep_last   = ({1'b0, rep_reg} + 4'd1) >= {1'b0, reps};
    end

    // config registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            one_width_reg  <= 11'd600;
            zero_width_reg <= 11'd400;
            on_extend_reg  <= 10'd150;
            off_trim_reg   <= 10'd200;
            repeat_reg     <= 3'd3;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                CFG_ONE_WIDTH:  one_width_reg  <= cfg_data;
                CFG_ZERO_WIDTH: zero_width_reg <= cfg_data;
                CFG_ON_EXTEND:  on_extend_reg  <= cfg_data[9:0];
                CFG_OFF_TRIM:   off_trim_reg   <= cfg_data[9:0];
                CFG_REPEAT:     repeat_reg     <= cfg_data[2:0];
                default:        ;
            endcase
        end
    end

    // payload, no reset
    always_ff @(posedge clk)
    begin
        if (accept)
            item_reg <= item;
        case (ctrl.op)
            OP_LATCH:
            begin
                house_reg <= item_reg.house_code;
                addr_reg  <= item_reg.device_address;
                cmd_reg   <= item_reg.command_byte;
                ext_reg   <= item_reg.extension_byte;
                csum_reg  <= (item_reg.heating_kind ? SEED_HEATING : SEED_SWITCH)
                           + item_reg.house_code[15:8];
            end
            OP_ADD_LO:   csum_reg <= csum_reg + house_reg[7:0];
            OP_ADD_ADDR: csum_reg <= csum_reg + addr_reg;
            OP_ADD_CMD:  csum_reg <= csum_reg + cmd_reg;
            OP_ADD_EXT:  csum_reg <= csum_reg + ext_reg;
            OP_BIT:
            begin
                bit_reg   <= bit_now;
                width_reg <= bit_now ? one_width_reg : zero_width_reg;
            end
            OP_EMIT:
            begin
                result_reg.bit_value   <= bit_reg;
                result_reg.on_time_us  <= on_time;
                result_reg.off_time_us <= off_time;
                result_reg.frame_end   <= frame_last;
                result_reg.message_end <= frame_last && rep_last;
            end
            default: ;
        endcase
    end

    // message position and strobe
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg       <= 1'b0;
            pos_reg          <= 7'd0;
            byte_reg         <= 3'd0;
            slot_reg         <= 4'd0;
            rep_reg          <= 3'd0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            result_valid_reg <= (ctrl.op == OP_EMIT);
            case (ctrl.op)
                OP_ARM:
                begin
                    active_reg <= 1'b1;
                    pos_reg    <= 7'd0;
                    byte_reg   <= 3'd0;
                    slot_reg   <= 4'd0;
                    rep_reg    <= 3'd0;
                end
                OP_EMIT:
                begin
                    if (frame_last)
                    begin
                        pos_reg  <= 7'd0;
                        byte_reg <= 3'd0;
                        slot_reg <= 4'd0;
                        if (rep_last)
                        begin
                            rep_reg    <= 3'd0;
                            active_reg <= 1'b0;
                        end
                        else
                            rep_reg <= rep_reg + 3'd1;
                    end
                    else
                    begin
                        pos_reg <= pos_reg + 7'd1;
                        if (pos_reg >= FIRST_BYTE_POS)
                        begin
                            if (slot_reg == PARITY_SLOT)
                            begin
                                slot_reg <= 4'd0;
                                byte_reg <= byte_reg + 3'd1;
                            end
                            else
                                slot_reg <= slot_reg + 4'd1;
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

endmodule

/* sim/tb_rf_remote_frame_pulse_encoder.sv */
`timescale 1ns / 1ps
// Testbench for rf_remote_frame_pulse_encoder: drives load/advance words and
// register writes, predicts every frame bit and checks each result word.
// Depends on rfpe_pkg and the encoder RTL.
module tb_rf_remote_frame_pulse_encoder;
    import rfpe_pkg::*;

    localparam int WORD_TARGET = 1900;
    localparam int QUIET_TAIL  = 250;

    class frame_scoreboard;
        logic [10:0] one_w;
        logic [10:0] zero_w;
        logic [9:0]  on_ext;
        logic [9:0]  off_trim;
        logic [2:0]  reps;
        logic [15:0] house;
        logic [7:0]  addr;
        logic [7:0]  cmd;
        logic [7:0]  extb;
        logic [7:0]  csum;
        int unsigned bit_pos;
        int unsigned rep_pos;
        bit          active;
        result_t     bits_due[$];
        int          errors;

        function new();
            one_w    = 11'd600;
            zero_w   = 11'd400;
            on_ext   = 10'd150;
            off_trim = 10'd200;
            reps     = 3'd3;
            house    = '0;
            addr     = '0;
            cmd      = '0;
            extb     = '0;
            csum     = '0;
            bit_pos  = 0;
            rep_pos  = 0;
            active   = 1'b0;
            errors   = 0;
        endfunction

        function void set_reg(logic [2:0] idx, logic [10:0] val);
            case (idx)
                CFG_ONE_WIDTH:  one_w    = val;
                CFG_ZERO_WIDTH: zero_w   = val;
                CFG_ON_EXTEND:  on_ext   = val[9:0];
                CFG_OFF_TRIM:   off_trim = val[9:0];
                CFG_REPEAT:     reps     = val[2:0];
                default: ;
            endcase
        endfunction

        function int unsigned byte_total();
            return cmd[EXT_BIT] ? BYTES_LONG : BYTES_SHORT;
        endfunction

        function int unsigned frame_len();
            return cmd[EXT_BIT] ? FRAME_BITS_LONG : FRAME_BITS_SHORT;
        endfunction

        function logic [7:0] byte_at_slot(int unsigned k);
            case (k)
                0: return house[15:8];
                1: return house[7:0];
                2: return addr;
                3: return cmd;
                4: return cmd[EXT_BIT] ? extb : csum;
                default: return csum;
            endcase
        endfunction

        // sync run, then bytes of 8 data bits and an even-parity bit, then a 0 tail
        function logic frame_bit(int unsigned p);
            int unsigned idx;
            logic [7:0]  b;
            if (p < SYNC_ONE_POS)
                return 1'b0;
            if (p == SYNC_ONE_POS)
                return 1'b1;
            idx = p - FIRST_BYTE_POS;
            if (idx / 9 >= byte_total())
                return 1'b0;
            b = byte_at_slot(idx / 9);
            if (idx % 9 < PARITY_SLOT)
                return b[7 - idx % 9];
            return ^b;
        endfunction

        function void absorb_word(item_t w);
            result_t     r;
            logic [10:0] width;
            logic [2:0]  eff;
            if (w.opcode == OPC_LOAD)
            begin
                if (active)
                    return;
                house   = w.house_code;
                addr    = w.device_address;
                cmd     = w.command_byte;
                extb    = w.extension_byte;
                csum    = (w.heating_kind ? SEED_HEATING : SEED_SWITCH) + house[15:8]
                        + house[7:0] + addr + cmd + (cmd[EXT_BIT] ? extb : 8'h00);
                bit_pos = 0;
                rep_pos = 0;
                active  = 1'b1;
                return;
            end
            if (!active)
                return;
            r.bit_value   = frame_bit(bit_pos);
            width         = r.bit_value ? one_w : zero_w;
            r.on_time_us  = {1'b0, width} + {2'b00, on_ext};
            r.off_time_us = (width > {1'b0, off_trim}) ? width - {1'b0, off_trim} : '0;
            r.frame_end   = (bit_pos + 1 >= frame_len());
            r.message_end = 1'b0;
            if (r.frame_end)
            begin
                eff     = (reps == 3'd0) ? 3'd1 : reps;
                bit_pos = 0;
                if (rep_pos + 1 >= eff)
                begin
                    r.message_end = 1'b1;
                    rep_pos       = 0;
                    active        = 1'b0;
                end
                else
                    rep_pos++;
            end
            else
                bit_pos++;
            bits_due.push_back(r);
        endfunction

        task report(string what);
            $display("%0t ns: MISMATCH %s", $time, what);
            errors++;
        endtask

        task check_bit(result_t got);
            result_t want;
            if (bits_due.size() == 0)
            begin
                report($sformatf("result word %h with nothing expected", got));
                return;
            end
            want = bits_due.pop_front();
            if (got.bit_value !== want.bit_value)
                report($sformatf("bit_value %b, expected %b", got.bit_value, want.bit_value));
            if (got.on_time_us !== want.on_time_us)
                report($sformatf("on_time_us %0d, expected %0d", got.on_time_us,
                                 want.on_time_us));
            if (got.off_time_us !== want.off_time_us)
                report($sformatf("off_time_us %0d, expected %0d", got.off_time_us,
                                 want.off_time_us));
            if (got.frame_end !== want.frame_end)
                report($sformatf("frame_end %b, expected %b", got.frame_end, want.frame_end));
            if (got.message_end !== want.message_end)
                report($sformatf("message_end %b, expected %b", got.message_end,
                                 want.message_end));
        endtask
    endclass

    logic        clk = 1'b0;
    logic        rst_n;
    logic        start;
    logic        busy;
    item_t       item;
    logic        result_valid;
    result_t     result;
    logic        cfg_wr_en;
    logic [2:0]  cfg_index;
    logic [10:0] cfg_data;

    frame_scoreboard sb;

    rf_remote_frame_pulse_encoder dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .item         (item),
        .result_valid (result_valid),
        .result       (result),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    always #10 clk = ~clk;

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (result_valid)
                sb.check_bit(result);
            if (start && !busy)
                sb.absorb_word(item);
            if (cfg_wr_en)
                sb.set_reg(cfg_index, cfg_data);
        end
    end

    function automatic item_t random_word();
        item_t w;
        w.opcode         = 1'($urandom);
        w.heating_kind   = 1'($urandom);
        w.house_code     = 16'($urandom);
        w.device_address = 8'($urandom);
        w.command_byte   = 8'($urandom);
        w.extension_byte = 8'($urandom);
        return w;
    endfunction

    function automatic logic [2:0] pick_repeat();
        int roll;
        roll = $urandom_range(0, 9);
        if (roll < 1)
            return 3'd0;
        if (roll < 5)
            return 3'd1;
        if (roll < 8)
            return 3'd2;
        return 3'($urandom_range(3, 7));
    endfunction

    // caller is at a falling edge; holds the word until it is taken
    task automatic put_word(item_t w);
        start = 1'b1;
        item  = w;
        forever
        begin
            @(posedge clk);
            if (!busy)
                break;
        end
    endtask

    task automatic hold_off(int n);
        repeat (n)
        begin
            @(negedge clk);
            start = 1'b0;
            item  = random_word();
        end
    endtask

    task automatic issue_random_word(output bit counted);
        item_t w;
        int    roll;
        @(negedge clk);
        w    = random_word();
        roll = $urandom_range(0, 99);
        if (sb.active)
            w.opcode = (roll < 4) ? OPC_LOAD : OPC_ADVANCE;
        else
            w.opcode = (roll < 88) ? OPC_LOAD : OPC_ADVANCE;
        counted = (w.opcode == OPC_LOAD) ? !sb.active : sb.active;
        put_word(w);
    endtask

    task automatic wait_idle();
        @(negedge clk);
        start = 1'b0;
        while (sb.bits_due.size() != 0 || busy)
            @(negedge clk);
        repeat (10) @(negedge clk);
    endtask

    task automatic write_reg(logic [2:0] idx, logic [10:0] val);
        @(negedge clk);
        cfg_wr_en = 1'b1;
        cfg_index = idx;
        cfg_data  = val;
    endtask

    task automatic apply_setting(int phase_no);
        logic [10:0] v_one;
        logic [10:0] v_zero;
        logic [10:0] v_ext;
        logic [10:0] v_trim;
        logic [10:0] v_rep;
        v_one       = 11'($urandom);
        v_zero      = 11'($urandom);
        v_ext       = 11'($urandom);
        v_trim      = 11'($urandom);
        v_rep       = 11'($urandom);
        v_rep[2:0]  = pick_repeat();
        case (phase_no)
            1:
            begin
                v_one      = '1;
                v_zero     = '0;
                v_ext      = '1;
                v_trim     = 11'h400;
                v_rep[2:0] = 3'd1;
            end
            2:
            begin
                v_one      = '0;
                v_zero     = '1;
                v_ext      = 11'h400;
                v_trim     = 11'h3ff;
                v_rep[2:0] = 3'd0;
            end
            3: v_rep[2:0] = 3'd7;
            default: ;
        endcase
        write_reg(CFG_ONE_WIDTH, v_one);
        write_reg(CFG_ZERO_WIDTH, v_zero);
        write_reg(CFG_ON_EXTEND, v_ext);
        write_reg(CFG_OFF_TRIM, v_trim);
        write_reg(CFG_REPEAT, v_rep);
        write_reg(3'($urandom_range(int'(CFG_REPEAT) + 1, 7)), 11'($urandom));
        @(negedge clk);
        cfg_wr_en = 1'b0;
    endtask

    initial
    begin
        item_t w;
        int    done_words;
        int    phase_no;
        int    budget;
        bit    gaps_on;
        bit    counted;
        sb        = new();
        rst_n     = 1'b0;
        start     = 1'b0;
        item      = '0;
        cfg_wr_en = 1'b0;
        cfg_index = CFG_ONE_WIDTH;
        cfg_data  = '0;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // advance with nothing loaded, full load, load while a message is active, then some bits
        @(negedge clk);
        w        = '1;
        w.opcode = OPC_ADVANCE;
        put_word(w);
        @(negedge clk);
        w        = '1;
        w.opcode = OPC_LOAD;
        put_word(w);
        @(negedge clk);
        w = '0;
        put_word(w);
        repeat (12)
        begin
            @(negedge clk);
            w        = random_word();
            w.opcode = OPC_ADVANCE;
            put_word(w);
        end

        done_words = 0;
        phase_no   = 0;
        while (done_words < WORD_TARGET)
        begin
            phase_no++;
            wait_idle();
            apply_setting(phase_no);
            gaps_on = ($urandom_range(0, 2) != 0);
            budget  = $urandom_range(40, 300);
            for (int i = 0; i < budget && done_words < WORD_TARGET; i++)
            begin
                if (gaps_on && done_words < WORD_TARGET - QUIET_TAIL
                    && $urandom_range(0, 7) == 0)
                    hold_off($urandom_range(1, 18));
                issue_random_word(counted);
                done_words += counted;
            end
        end

        wait_idle();
        repeat (20) @(negedge clk);
        if (sb.errors == 0 && sb.bits_due.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

    initial
    begin
        #10_000_000;
        $display("simulation failed");
        $finish;
    end

endmodule
